// ===== sv/i2cm_pkg.sv =====
// shared types and constants for the open-drain i2c bit-level master
// used by every module of the block; no dependencies
package i2cm_pkg;

   localparam logic [15:0] UNIT_DELAY_RESET = 16'd5000;
   localparam int          CLEAR_PULSES     = 5;
   localparam int          MAX_READ         = 31;
   localparam int          QUEUE_DEPTH_DEF  = 4;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_CLEAR = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      PIN_KEEP = 2'd0,
      PIN_LOW  = 2'd1,
      PIN_REL  = 2'd2
   } pin_op_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] write_byte;
      logic [4:0] read_count;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] read_byte;
      logic       byte_valid;
   } rsp_payload_type;

   // classified tick as it travels from front to back
   typedef struct packed {
      logic       is_cmd;
      cmd_type    cmd;
      logic [7:0] write_byte;
      logic [4:0] read_count;
      logic       sda_in;
   } tick_item_type;

   typedef struct packed {
      pin_op_type scl_op;
      pin_op_type sda_op;
      logic       whole_unit;
   } step_type;

endpackage

// ===== sv/i2cm_front.sv =====
// front end: decodes the command kind of each incoming tick
// and saturates the read count; depends on i2cm_pkg
module i2cm_front
   import i2cm_pkg::*;
(
   input  req_payload_type req_payload,
   output tick_item_type   item
);

   always_comb begin
      item.write_byte = req_payload.write_byte;
      item.sda_in     = req_payload.sda_in;
      if ({3'b000, req_payload.read_count} > 8'(MAX_READ)) begin
         item.read_count = 5'(MAX_READ);
      end else begin
         item.read_count = req_payload.read_count;
      end
      unique case (req_payload.kind)
         CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_CLEAR: begin
            item.is_cmd = 1'b1;
            item.cmd    = cmd_type'(req_payload.kind);
         end
         default: begin
            // kind zero and the spare kinds six and seven carry no command
            item.is_cmd = 1'b0;
            item.cmd    = CMD_NONE;
         end
      endcase
   end

endmodule

// ===== sv/i2cm_queue.sv =====
// short fifo of classified ticks between front and back
// depends on i2cm_pkg
module i2cm_queue
   import i2cm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tick_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output tick_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tick_item_type          mem [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/i2cm_back.sv =====
// back end: bit sequencer that runs start, stop, write, read and bus clear
// one tick per cycle unless rsp stalls, plus the registered result stage; depends on i2cm_pkg
module i2cm_back
   import i2cm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [15:0]     csr_write_data,
   input  logic            item_valid,
   input  tick_item_type   item,
   output logic            item_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [15:0]     unit_ff;
   cmd_type         cmd_ff, cmd_in;
   logic [3:0]      phase_ff, phase_in;
   logic [3:0]      bit_ff, bit_in;
   logic [4:0]      bytes_ff, bytes_in;
   logic [15:0]     delay_ff, delay_in;
   logic [7:0]      shift_ff, shift_in;
   logic            scl_ff, scl_in;
   logic            sda_ff, sda_in;
   logic            ack_ff, ack_in;
   logic [7:0]      last_ff, last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [15:0]     unit_m1;
   logic            done;
   logic            byte_new;
   logic            do_load;
   logic [4:0]      pulse_next;
   step_type        step;

   // pin levels and hold length of the step at a given phase
   function automatic step_type step_of(cmd_type c, logic [3:0] p, logic [3:0] b,
                                        logic [7:0] sb);
      step_type s;
      s.whole_unit = 1'b1;
      s.scl_op     = PIN_REL;
      s.sda_op     = PIN_KEEP;
      case (c)
         CMD_START: begin
            if (p < 4'd2) begin
               s.scl_op = PIN_REL;  s.sda_op = PIN_KEEP;
            end else if (p == 4'd2) begin
               s.scl_op = PIN_REL;  s.sda_op = PIN_LOW;  s.whole_unit = 1'b0;
            end else begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_LOW;
            end
         end
         CMD_STOP: begin
            if (p == 4'd0) begin
               s.scl_op = PIN_KEEP; s.sda_op = PIN_LOW;  s.whole_unit = 1'b0;
            end else if (p < 4'd3) begin
               s.scl_op = PIN_REL;  s.sda_op = PIN_LOW;
            end else begin
               s.scl_op = PIN_REL;  s.sda_op = PIN_REL;
            end
         end
         CMD_WRITE: begin
            if (p == 4'd0) begin
               s.scl_op = PIN_LOW;
               s.sda_op = sb[3'd7 - b[2:0]] ? PIN_REL : PIN_LOW;
            end else if (p == 4'd4) begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_REL;
            end else if (p == 4'd3 || p == 4'd7) begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_KEEP;
            end else begin
               s.scl_op = PIN_REL;  s.sda_op = PIN_KEEP;
            end
         end
         CMD_READ: begin
            if (p == 4'd0) begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_REL;
            end else if (p == 4'd5) begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_LOW;
            end else if (p == 4'd1 || p == 4'd4 || p == 4'd8) begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_KEEP;
            end else begin
               s.scl_op = PIN_REL;  s.sda_op = PIN_KEEP;
            end
         end
         default: begin
            if (p == 4'd0) begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_REL;
            end else if (p == 4'd3) begin
               s.scl_op = PIN_LOW;  s.sda_op = PIN_KEEP;
            end else begin
               s.scl_op = PIN_REL;  s.sda_op = PIN_KEEP;
            end
         end
      endcase
      return s;
   endfunction

   assign item_pop    = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign unit_m1     = (unit_ff == 16'd0) ? 16'd0 : unit_ff - 16'd1;
   assign pulse_next  = {1'b0, bit_ff} + 5'd1;

   // next sequencer state
   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      bytes_in = bytes_ff;
      delay_in = delay_ff;
      shift_in = shift_ff;
      ack_in   = ack_ff;
      last_in  = last_ff;
      done     = 1'b0;
      byte_new = 1'b0;
      do_load  = 1'b0;

      if (cmd_ff != CMD_NONE) begin
         if (delay_ff != 16'd0) begin
            delay_in = delay_ff - 16'd1;
         end else begin
            do_load = 1'b1;
            case (cmd_ff)
               CMD_START, CMD_STOP: begin
                  if (phase_ff >= 4'd4) begin
                     done = 1'b1;
                  end else begin
                     phase_in = phase_ff + 4'd1;
                  end
               end
               CMD_WRITE: begin
                  // ack sampled at mid scl-high
                  if (phase_ff == 4'd5) begin
                     ack_in = ~item.sda_in;
                  end
                  if (phase_ff == 4'd3) begin
                     bit_in   = bit_ff + 4'd1;
                     phase_in = (bit_in < 4'd8) ? 4'd0 : 4'd4;
                  end else if (phase_ff >= 4'd7) begin
                     done = 1'b1;
                  end else begin
                     phase_in = phase_ff + 4'd1;
                  end
               end
               CMD_READ: begin
                  if (phase_ff == 4'd2) begin
                     shift_in = {shift_ff[6:0], item.sda_in};
                  end
                  if (phase_ff == 4'd4) begin
                     bit_in = bit_ff + 4'd1;
                     if (bit_in < 4'd8) begin
                        phase_in = 4'd1;
                     end else begin
                        last_in  = shift_ff;
                        byte_new = 1'b1;
                        phase_in = 4'd5;
                     end
                  end else if (phase_ff >= 4'd8) begin
                     bytes_in = (bytes_ff != 5'd0) ? bytes_ff - 5'd1 : 5'd0;
                     if (bytes_in == 5'd0) begin
                        done = 1'b1;
                     end else begin
                        phase_in = 4'd0;
                        bit_in   = 4'd0;
                     end
                  end else begin
                     phase_in = phase_ff + 4'd1;
                  end
               end
               CMD_CLEAR: begin
                  if (phase_ff >= 4'd3) begin
                     bit_in = pulse_next[3:0];
                     if (pulse_next >= 5'(CLEAR_PULSES)) begin
                        done = 1'b1;
                     end else begin
                        phase_in = 4'd0;
                     end
                  end else begin
                     phase_in = phase_ff + 4'd1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               cmd_in   = CMD_NONE;
               phase_in = 4'd0;
               do_load  = 1'b0;
            end
         end
      end else if (item.is_cmd) begin
         cmd_in   = item.cmd;
         phase_in = 4'd0;
         bit_in   = 4'd0;
         do_load  = 1'b1;
         if (item.cmd == CMD_WRITE) begin
            shift_in = item.write_byte;
         end
         if (item.cmd == CMD_READ) begin
            shift_in = 8'd0;
            bytes_in = item.read_count;
            // zero-length read completes at once with no bus activity
            if (item.read_count == 5'd0) begin
               cmd_in  = CMD_NONE;
               done    = 1'b1;
               do_load = 1'b0;
            end
         end
      end
   end

   // pin levels of the step being entered
   always_comb begin
      step   = step_of(cmd_in, phase_in, bit_in, shift_in);
      scl_in = scl_ff;
      sda_in = sda_ff;
      if (do_load) begin
         case (step.scl_op)
            PIN_LOW: scl_in = 1'b1;
            PIN_REL: scl_in = 1'b0;
            default: scl_in = scl_ff;
         endcase
         case (step.sda_op)
            PIN_LOW: sda_in = 1'b1;
            PIN_REL: sda_in = 1'b0;
            default: sda_in = sda_ff;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_in.scl_drive_low = scl_in;
      rsp_in.sda_drive_low = sda_in;
      rsp_in.busy_res      = (cmd_in != CMD_NONE);
      rsp_in.done_res      = done;
      rsp_in.ack_ok        = ack_in;
      rsp_in.read_byte     = last_in;
      rsp_in.byte_valid    = byte_new;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_DELAY_RESET;
      end else if (csr_write_enable) begin
         unit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_NONE;
         phase_ff     <= '0;
         bit_ff       <= '0;
         bytes_ff     <= '0;
         delay_ff     <= '0;
         shift_ff     <= '0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b0;
         ack_ff       <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            bytes_ff <= bytes_in;
            delay_ff <= do_load ? (step.whole_unit ? unit_m1 : 16'd0) : delay_in;
            shift_ff <= shift_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            last_ff  <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== sv/i2c_bit_level_master_unit.sv =====
// open-drain i2c bit-level master, top level
// instantiates i2cm_front, i2cm_queue and i2cm_back; depends on i2cm_pkg
//
// every req transaction is one bus tick: an optional command (start, stop,
// write byte, read bytes, bus clear) and the sampled sda level. every tick
// yields exactly one rsp transaction with the scl/sda drive-low levels,
// busy, done, the write ack flag and the last received byte.
// commands arriving while busy are dropped; csr_write_data sets the number
// of ticks per timing unit (zero acts as one). it is to be written only when
// idle; the block itself does not enforce this. a tick accepted into the fifo
// is loaded into the result register as it is popped, then offered on rsp.
// throughput: one tick per cycle while rsp_stall is low; the sequencer updates
// its state once per popped tick, so ticks can follow back to back.
// the front decodes ticks into a QUEUE_DEPTH entry fifo; the back pops one
// per cycle into a single result register. when rsp_stall is high the
// result holds and the fifo fills; req_stall rises once it is full.
// reset (synchronous) empties the fifo, drops the pending result, releases
// both pins, clears flags and loads the unit delay with 5000. there is no
// clearing pass; the block accepts ticks on the cycle after reset.
module i2c_bit_level_master_unit
   import i2cm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [15:0]     csr_write_data
);

   tick_item_type front_item;
   tick_item_type queue_item;
   logic          queue_full;
   logic          queue_not_empty;
   logic          queue_pop;

   assign req_stall = queue_full;

   i2cm_front u_front (
      .req_payload (req_payload),
      .item        (front_item)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !queue_full),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_item  (queue_item)
   );

   i2cm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (queue_not_empty),
      .item             (queue_item),
      .item_pop         (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

// ===== sv/i2cm_checker.sv =====
// port-level checks for the i2c bit-level master
// bound to i2c_bit_level_master_unit; depends on i2cm_pkg
module i2cm_checker
   import i2cm_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // reset drops any pending result
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // reset empties the queue
   a_reset_req: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("req_stall high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // a new read byte only appears in the middle of a read
   a_byte_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_valid |->
         rsp_payload.busy_res && !rsp_payload.done_res)
      else $error("byte_valid outside a running read");

   // completion is shown with busy already cleared
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_res |-> !rsp_payload.busy_res)
      else $error("done_res while busy");

endmodule

bind i2c_bit_level_master_unit i2cm_checker u_i2cm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for i2c_bit_level_master_unit, one bus tick per transaction
// depends on i2cm_pkg and the i2c_bit_level_master_unit rtl; nothing else
module tb
   import i2cm_pkg::*;
();

   localparam int          RESULT_LATENCY = 2;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          PRESSURE_HOLD  = 64;
   localparam int          SEG_COUNT      = 8;
   localparam int          SEG_TICKS      = 24;
   localparam int          PLAN_ROWS      = 17;
   localparam int          PRINT_CAP      = 60;
   localparam logic [15:0] LONG_UNIT      = 16'd1000;
   localparam logic [2:0]  KIND_SPARE_LO  = 3'd6;
   localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;
   localparam logic [15:0] SEG_DELAY [SEG_COUNT] = '{16'd1, 16'd0, 16'd3, 16'd1,
                                                     16'd2, 16'd4, 16'd1, 16'd6};

   // level the slave puts on sda while a command runs
   typedef enum logic [1:0] {
      SDA_LOW  = 2'd0,
      SDA_HIGH = 2'd1,
      SDA_RAND = 2'd2
   } sda_mode_type;

   typedef struct packed {
      logic            set_delay;
      logic [15:0]     delay_value;
      req_payload_type tick;
      sda_mode_type    line;
      logic            typed;
      rsp_payload_type want;
   } plan_row_type;

   localparam rsp_payload_type QUIET      = '0;
   localparam rsp_payload_type QUIET_DONE = '{scl_drive_low: 1'b0, sda_drive_low: 1'b0,
                                              busy_res: 1'b0, done_res: 1'b1, ack_ok: 1'b0,
                                              read_byte: 8'h00, byte_valid: 1'b0};

   // directed part; each command row is clocked through to completion
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{1'b0, 16'd0,     '{CMD_NONE,      8'h00, 5'd0,  1'b1}, SDA_RAND, 1'b1, QUIET},
      '{1'b0, 16'd0,     '{KIND_SPARE_LO, 8'hFF, 5'd31, 1'b0}, SDA_RAND, 1'b1, QUIET},
      '{1'b0, 16'd0,     '{KIND_SPARE_HI, 8'h00, 5'd0,  1'b1}, SDA_RAND, 1'b1, QUIET},
      '{1'b0, 16'd0,     '{CMD_READ,      8'hFF, 5'd0,  1'b1}, SDA_RAND, 1'b1, QUIET_DONE},
      '{1'b1, 16'd0,     '{CMD_STOP,      8'h00, 5'd0,  1'b0}, SDA_RAND, 1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_START,     8'h00, 5'd0,  1'b1}, SDA_RAND, 1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_START,     8'h00, 5'd0,  1'b0}, SDA_RAND, 1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_WRITE,     8'hFF, 5'd0,  1'b0}, SDA_LOW,  1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_WRITE,     8'h00, 5'd0,  1'b1}, SDA_HIGH, 1'b0, QUIET},
      '{1'b1, 16'd1,     '{CMD_WRITE,     8'hA5, 5'd0,  1'b0}, SDA_RAND, 1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_READ,      8'h00, 5'd1,  1'b1}, SDA_HIGH, 1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_READ,      8'hFF, 5'd1,  1'b0}, SDA_LOW,  1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_READ,      8'h5A, 5'd31, 1'b1}, SDA_RAND, 1'b0, QUIET},
      '{1'b1, 16'd2,     '{CMD_CLEAR,     8'h00, 5'd0,  1'b0}, SDA_RAND, 1'b0, QUIET},
      '{1'b0, 16'd0,     '{CMD_STOP,      8'h00, 5'd0,  1'b1}, SDA_RAND, 1'b0, QUIET},
      '{1'b1, 16'd12,    '{CMD_START,     8'h00, 5'd0,  1'b1}, SDA_RAND, 1'b0, QUIET},
      '{1'b1, 16'd1,     '{CMD_CLEAR,     8'hFF, 5'd31, 1'b0}, SDA_LOW,  1'b0, QUIET}
   };

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_stall;
   req_payload_type req_payload      = '0;
   logic            rsp_valid;
   logic            rsp_stall        = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [15:0]     csr_write_data   = 16'd0;

   // predictor state
   logic [15:0] unit_delay_q = UNIT_DELAY_RESET;
   cmd_type     cur_cmd      = CMD_NONE;
   int unsigned step_q       = 0;
   int unsigned bit_q        = 0;
   int unsigned bytes_left_q = 0;
   int unsigned wait_q       = 0;
   logic [7:0]  shift_q      = 8'h00;
   logic [7:0]  last_read_q  = 8'h00;
   logic        scl_low_q    = 1'b0;
   logic        sda_low_q    = 1'b0;
   logic        ack_q        = 1'b0;

   rsp_payload_type bus_states_due [$];

   int mismatches    = 0;
   int results_seen  = 0;
   int ticks_sent    = 0;
   int commands_run  = 0;
   int done_seen     = 0;
   int bytes_read    = 0;
   int settings_used = 1;
   int hold_left     = 0;
   int stall_left    = 0;
   int idle_cycles   = 0;
   int xfer_left     = 0;
   bit steady        = 1'b0;

   i2c_bit_level_master_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] result %0d: %s", $time, results_seen, msg);
   endtask

   // gap length for either side; long unit delays run without gaps to keep the run short
   function automatic int pick_pause();
      int r;
      if (steady || hold_left > 0 || unit_delay_q >= LONG_UNIT) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 60) return 0;
      if (r < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(6, 40));
   endfunction

   function automatic void set_pins(input pin_op_type scl_op, input pin_op_type sda_op,
                                    input bit whole);
      int unsigned units;
      units = (unit_delay_q == 16'd0) ? 32'd1 : 32'(unit_delay_q);
      if (scl_op == PIN_LOW) scl_low_q = 1'b1;
      else if (scl_op == PIN_REL) scl_low_q = 1'b0;
      if (sda_op == PIN_LOW) sda_low_q = 1'b1;
      else if (sda_op == PIN_REL) sda_low_q = 1'b0;
      wait_q = whole ? units - 1 : 0;
   endfunction

   // pin levels and length of the bus step the sequencer has just entered
   function automatic void enter_step();
      case (cur_cmd)
         CMD_START: begin
            if (step_q < 2) set_pins(PIN_REL, PIN_KEEP, 1'b1);
            else if (step_q == 2) set_pins(PIN_REL, PIN_LOW, 1'b0);
            else set_pins(PIN_LOW, PIN_LOW, 1'b1);
         end
         CMD_STOP: begin
            if (step_q == 0) set_pins(PIN_KEEP, PIN_LOW, 1'b0);
            else if (step_q < 3) set_pins(PIN_REL, PIN_LOW, 1'b1);
            else set_pins(PIN_REL, PIN_REL, 1'b1);
         end
         CMD_WRITE: begin
            if (step_q == 0)
               set_pins(PIN_LOW, shift_q[7 - (bit_q % 8)] ? PIN_REL : PIN_LOW, 1'b1);
            else if (step_q == 4) set_pins(PIN_LOW, PIN_REL, 1'b1);
            else if (step_q == 3 || step_q == 7) set_pins(PIN_LOW, PIN_KEEP, 1'b1);
            else set_pins(PIN_REL, PIN_KEEP, 1'b1);
         end
         CMD_READ: begin
            if (step_q == 0) set_pins(PIN_LOW, PIN_REL, 1'b1);
            else if (step_q == 5) set_pins(PIN_LOW, PIN_LOW, 1'b1);
            else if (step_q == 1 || step_q == 4 || step_q == 8) set_pins(PIN_LOW, PIN_KEEP, 1'b1);
            else set_pins(PIN_REL, PIN_KEEP, 1'b1);
         end
         default: begin
            if (step_q == 0) set_pins(PIN_LOW, PIN_REL, 1'b1);
            else if (step_q == 3) set_pins(PIN_LOW, PIN_KEEP, 1'b1);
            else set_pins(PIN_REL, PIN_KEEP, 1'b1);
         end
      endcase
   endfunction

   // closes the current step, takes its sample; returns 1 when the command is over
   function automatic bit finish_step(input logic sda, output logic fresh);
      fresh = 1'b0;
      case (cur_cmd)
         CMD_START, CMD_STOP: begin
            if (step_q >= 4) return 1'b1;
            step_q++;
         end
         CMD_WRITE: begin
            if (step_q == 5) ack_q = ~sda;
            if (step_q == 3) begin
               bit_q = (bit_q + 1) & 15;
               step_q = (bit_q < 8) ? 0 : 4;
               return 1'b0;
            end
            if (step_q >= 7) return 1'b1;
            step_q++;
         end
         CMD_READ: begin
            if (step_q == 2) shift_q = {shift_q[6:0], sda};
            if (step_q == 4) begin
               bit_q = (bit_q + 1) & 15;
               if (bit_q < 8) begin
                  step_q = 1;
               end else begin
                  last_read_q = shift_q;
                  fresh = 1'b1;
                  step_q = 5;
               end
               return 1'b0;
            end
            if (step_q >= 8) begin
               bytes_left_q = (bytes_left_q > 0) ? bytes_left_q - 1 : 0;
               if (bytes_left_q == 0) return 1'b1;
               step_q = 0;
               bit_q = 0;
               return 1'b0;
            end
            step_q++;
         end
         CMD_CLEAR: begin
            if (step_q >= 3) begin
               bit_q = (bit_q + 1) & 31;
               if (bit_q >= CLEAR_PULSES) return 1'b1;
               step_q = 0;
               return 1'b0;
            end
            step_q++;
         end
         default: return 1'b1;
      endcase
      return 1'b0;
   endfunction

   // advances the predicted sequencer by one tick and returns the pins and flags it shows
   function automatic rsp_payload_type step_bus(input req_payload_type t);
      rsp_payload_type r;
      logic            done;
      logic            fresh;
      logic            over;
      int unsigned     n;
      done  = 1'b0;
      fresh = 1'b0;
      if (cur_cmd != CMD_NONE) begin
         if (wait_q > 0) begin
            wait_q--;
         end else begin
            over = finish_step(t.sda_in, fresh);
            if (over) begin
               cur_cmd = CMD_NONE;
               step_q  = 0;
               done    = 1'b1;
            end else begin
               enter_step();
            end
         end
      end else if (t.kind >= CMD_START && t.kind <= CMD_CLEAR) begin
         cur_cmd = cmd_type'(t.kind);
         step_q  = 0;
         bit_q   = 0;
         commands_run++;
         if (cur_cmd == CMD_WRITE) shift_q = t.write_byte;
         if (cur_cmd == CMD_READ) begin
            n = (int'(t.read_count) > MAX_READ) ? MAX_READ : 32'(t.read_count);
            shift_q      = 8'h00;
            bytes_left_q = n;
            // zero-length read finishes on the tick that takes it
            if (n == 0) begin
               cur_cmd = CMD_NONE;
               done    = 1'b1;
            end
         end
         if (cur_cmd != CMD_NONE) enter_step();
      end
      if (done) done_seen++;
      if (fresh) bytes_read++;
      r.scl_drive_low = scl_low_q;
      r.sda_drive_low = sda_low_q;
      r.busy_res      = (cur_cmd != CMD_NONE);
      r.done_res      = done;
      r.ack_ok        = ack_q;
      r.read_byte     = last_read_q;
      r.byte_valid    = fresh;
      return r;
   endfunction

   // tick sent while a command runs; its command bits must be ignored
   function automatic req_payload_type filler(input sda_mode_type mode);
      req_payload_type f;
      f.kind       = 3'($urandom_range(0, 7));
      f.write_byte = 8'($urandom_range(0, 255));
      f.read_count = 5'($urandom_range(0, 31));
      f.sda_in     = (mode == SDA_RAND) ? 1'($urandom_range(0, 1)) : (mode == SDA_HIGH);
      return f;
   endfunction

   // mostly start, one to three writes or reads, then stop; the rest is clears and noise
   function automatic req_payload_type next_bus_command();
      req_payload_type c;
      int              r;
      c = filler(SDA_RAND);
      r = int'($urandom_range(0, 99));
      if (r < 60) c.read_count = 5'($urandom_range(1, 2));
      else c.read_count = 5'($urandom_range(0, 7));
      r = int'($urandom_range(0, 19));
      if (r < 2) begin
         c.kind = CMD_CLEAR;
      end else if (r < 5) begin
         c.kind = 3'($urandom_range(0, 7));
      end else if (xfer_left == 0) begin
         c.kind    = CMD_START;
         xfer_left = int'($urandom_range(2, 4));
      end else if (xfer_left == 1) begin
         c.kind    = CMD_STOP;
         xfer_left = 0;
      end else begin
         c.kind = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_WRITE;
         xfer_left--;
      end
      return c;
   endfunction

   task automatic send_tick(input req_payload_type item, input logic typed,
                            input rsp_payload_type want);
      int              pause;
      rsp_payload_type guess;
      pause = pick_pause();
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      guess = step_bus(item);
      bus_states_due.push_back(typed ? want : guess);
      ticks_sent++;
   endtask

   // only with the sequencer idle and every result back
   task automatic write_unit_delay(input logic [15:0] value);
      req_valid <= 1'b0;
      while (bus_states_due.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      unit_delay_q = value;
      settings_used++;
   endtask

   initial begin : stimulus
      int row;
      int seg;
      int count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_ROWS; row++) begin
         if (PLAN[row].set_delay) write_unit_delay(PLAN[row].delay_value);
         send_tick(PLAN[row].tick, PLAN[row].typed, PLAN[row].want);
         while (cur_cmd != CMD_NONE) send_tick(filler(PLAN[row].line), 1'b0, QUIET);
      end

      for (seg = 0; seg < SEG_COUNT; seg++) begin
         write_unit_delay(SEG_DELAY[seg]);
         steady = (seg == 2 || seg == 5);
         count  = 0;
         while (count < SEG_TICKS || cur_cmd != CMD_NONE) begin
            if (cur_cmd == CMD_NONE) send_tick(next_bus_command(), 1'b0, QUIET);
            else send_tick(filler(SDA_RAND), 1'b0, QUIET);
            count++;
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (bus_states_due.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 8) @(posedge clock);
      $display("run covered %0d ticks under %0d unit delay settings, %0d commands started",
               ticks_sent, settings_used, commands_run);
      $display("%0d commands finished, %0d bytes read back, %0d results compared",
               done_seen, bytes_read, results_seen);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   always @(posedge clock) begin : rsp_side
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (bus_states_due.size() == 0) begin
               report("result with no tick outstanding");
            end else begin
               want = bus_states_due.pop_front();
               if (rsp_payload.scl_drive_low !== want.scl_drive_low)
                  report($sformatf("scl_drive_low %b, expected %b",
                                   rsp_payload.scl_drive_low, want.scl_drive_low));
               if (rsp_payload.sda_drive_low !== want.sda_drive_low)
                  report($sformatf("sda_drive_low %b, expected %b",
                                   rsp_payload.sda_drive_low, want.sda_drive_low));
               if (rsp_payload.busy_res !== want.busy_res)
                  report($sformatf("busy_res %b, expected %b",
                                   rsp_payload.busy_res, want.busy_res));
               if (rsp_payload.done_res !== want.done_res)
                  report($sformatf("done_res %b, expected %b",
                                   rsp_payload.done_res, want.done_res));
               if (rsp_payload.ack_ok !== want.ack_ok)
                  report($sformatf("ack_ok %b, expected %b",
                                   rsp_payload.ack_ok, want.ack_ok));
               if (rsp_payload.read_byte !== want.read_byte)
                  report($sformatf("read_byte %h, expected %h",
                                   rsp_payload.read_byte, want.read_byte));
               if (rsp_payload.byte_valid !== want.byte_valid)
                  report($sformatf("byte_valid %b, expected %b",
                                   rsp_payload.byte_valid, want.byte_valid));
            end
            results_seen++;
            // long hold-off so the fifo fills and the input side backs up
            if (unit_delay_q < LONG_UNIT && results_seen % 700 == 350)
               hold_left = PRESSURE_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left = pick_pause();
         end
      end
   end

   // ends the run when no transaction moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, bus_states_due.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_queue.sv
sv/i2cm_back.sv
sv/i2c_bit_level_master_unit.sv
sv/i2cm_checker.sv
tb/tb.sv
